[hdl/lbd_pkg.sv]
`timescale 1ns / 1ps

package lbd_pkg;

    localparam int ROW_SUM_W = 22;
    localparam int IMG_SUM_W = 35;
    localparam int IMG_LIM_W = 34;
    localparam int LEVEL_W   = 8;
    localparam int SAMPLE_W  = 8;
    localparam int CNT_W     = 13;
    localparam int CNT_LIMIT = 8191;

    localparam int MAX_ROWS_DEF = 4096;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_W  = 2;

    localparam logic [ROW_SUM_W-1:0] ROW_SUM_LIMIT_RST = ROW_SUM_W'(3264);
    localparam logic [IMG_LIM_W-1:0] IMG_SUM_LIMIT_RST = IMG_LIM_W'(391680);
    localparam logic [LEVEL_W-1:0]   BRIGHT_LEVEL_RST  = LEVEL_W'(25);

    typedef enum logic [REG_IDX_W-1:0] {
        REG_ROW_SUM_LIMIT = 2'd0,
        REG_IMG_SUM_LIMIT = 2'd1,
        REG_BRIGHT_LEVEL  = 2'd2
    } t_reg_idx;

    typedef enum logic [1:0] {
        OUTCOME_CROP     = 2'd0,
        OUTCOME_DARK     = 2'd1,
        OUTCOME_ALL_BARS = 2'd2
    } t_outcome;

endpackage

[hdl/letterbox_bar_detector_unit.sv]
`timescale 1ns / 1ps

// Letterbox bar detector. Takes one 8-bit sample word per clock in raster
// order (all channels of a row together), flagged at row end and image end,
// and returns one result word per image: leading and trailing bar rows to
// crop, an outcome code and the row count. Every sample is folded into the
// running row and image sums in the cycle it is accepted, so the input side
// sustains one word per cycle. The result sits in an output register; only
// an image-end word stalls, and only while the previous result is still
// untaken. The result appears in the cycle after its image-end word is taken.
// Thresholds are set through the APB port at byte addresses 0, 8 and 16.
module letterbox_bar_detector_unit #(
    parameter int MAX_ROWS = lbd_pkg::MAX_ROWS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lbd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lbd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lbd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,

    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [lbd_pkg::SAMPLE_W-1:0]     i_sample,
    input  logic                             i_row_end,
    input  logic                             i_image_end,

    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [lbd_pkg::CNT_W-1:0]        o_top_rows,
    output logic [lbd_pkg::CNT_W-1:0]        o_bottom_rows,
    output logic [1:0]                       o_outcome,
    output logic [lbd_pkg::CNT_W-1:0]        o_total_rows
);
    import lbd_pkg::*;

    localparam int CNT_CAP_I = (MAX_ROWS < CNT_LIMIT) ? MAX_ROWS : CNT_LIMIT;
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CNT_CAP_I);

    // configuration
    logic [ROW_SUM_W-1:0] r_row_sum_limit;
    logic [IMG_LIM_W-1:0] r_img_sum_limit;
    logic [LEVEL_W-1:0]   r_bright_level;
    t_reg_idx             w_reg_idx;
    logic                 w_cfg_wr;

    // per-image state
    logic [ROW_SUM_W-1:0] r_row_sum,        n_row_sum;
    logic                 r_row_has_bright, n_row_has_bright;
    logic [IMG_SUM_W-1:0] r_img_sum,        n_img_sum;
    logic [CNT_W-1:0]     r_lead_cnt,       n_lead_cnt;
    logic                 r_still_lead,     n_still_lead;
    logic [CNT_W-1:0]     r_trail_cnt,      n_trail_cnt;
    logic [CNT_W-1:0]     r_row_cnt,        n_row_cnt;

    // result register
    logic                 r_out_valid;
    logic [CNT_W-1:0]     r_top_rows, r_bottom_rows, r_total_rows;
    t_outcome             r_outcome;

    logic                 w_accept;
    logic [ROW_SUM_W:0]   w_row_acc;
    logic [IMG_SUM_W:0]   w_img_acc;
    logic [ROW_SUM_W-1:0] w_row_sum;
    logic [IMG_SUM_W-1:0] w_img_sum;
    logic                 w_row_bright;
    logic                 w_row_done;
    logic                 w_bar;
    logic [CNT_W-1:0]     w_row_cnt_inc, w_lead_cnt_inc, w_trail_cnt_inc;
    logic [CNT_W-1:0]     w_lead_cnt, w_trail_cnt, w_row_cnt;
    logic                 w_still_lead;
    t_outcome             w_outcome;

    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        case (w_reg_idx)
            REG_ROW_SUM_LIMIT: prdata = APB_DATA_W'(r_row_sum_limit);
            REG_IMG_SUM_LIMIT: prdata = APB_DATA_W'(r_img_sum_limit);
            REG_BRIGHT_LEVEL:  prdata = APB_DATA_W'(r_bright_level);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_sum_limit <= ROW_SUM_LIMIT_RST;
            r_img_sum_limit <= IMG_SUM_LIMIT_RST;
            r_bright_level  <= BRIGHT_LEVEL_RST;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_ROW_SUM_LIMIT: r_row_sum_limit <= pwdata[ROW_SUM_W-1:0];
                REG_IMG_SUM_LIMIT: r_img_sum_limit <= pwdata[IMG_LIM_W-1:0];
                REG_BRIGHT_LEVEL:  r_bright_level  <= pwdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Only an image-end word needs the result register.
    assign o_ready  = !r_out_valid || i_ready || !i_image_end;
    assign w_accept = i_valid && o_ready;

    // Saturating sums.
    assign w_row_acc = {1'b0, r_row_sum} + (ROW_SUM_W+1)'(i_sample);
    assign w_img_acc = {1'b0, r_img_sum} + (IMG_SUM_W+1)'(i_sample);
    assign w_row_sum = w_row_acc[ROW_SUM_W] ? '1 : w_row_acc[ROW_SUM_W-1:0];
    assign w_img_sum = w_img_acc[IMG_SUM_W] ? '1 : w_img_acc[IMG_SUM_W-1:0];

    assign w_row_bright = r_row_has_bright || (i_sample > r_bright_level);
    assign w_row_done   = i_row_end || i_image_end;
    assign w_bar        = (w_row_sum < r_row_sum_limit) && !w_row_bright;

    assign w_row_cnt_inc   = (r_row_cnt   < CNT_CAP) ? r_row_cnt   + 1'b1 : r_row_cnt;
    assign w_lead_cnt_inc  = (r_lead_cnt  < CNT_CAP) ? r_lead_cnt  + 1'b1 : r_lead_cnt;
    assign w_trail_cnt_inc = (r_trail_cnt < CNT_CAP) ? r_trail_cnt + 1'b1 : r_trail_cnt;

    always_comb begin
        w_row_cnt    = r_row_cnt;
        w_lead_cnt   = r_lead_cnt;
        w_trail_cnt  = r_trail_cnt;
        w_still_lead = r_still_lead;
        if (w_row_done) begin
            w_row_cnt = w_row_cnt_inc;
            if (w_bar) begin
                if (r_still_lead) begin
                    w_lead_cnt = w_lead_cnt_inc;
                end
                w_trail_cnt = w_trail_cnt_inc;
            end else begin
                w_still_lead = 1'b0;
                w_trail_cnt  = '0;
            end
        end
    end

    always_comb begin
        if (w_img_sum < {1'b0, r_img_sum_limit}) begin
            w_outcome = OUTCOME_DARK;
        end else if (w_still_lead) begin
            w_outcome = OUTCOME_ALL_BARS;
        end else begin
            w_outcome = OUTCOME_CROP;
        end
    end

    always_comb begin
        n_row_sum        = w_row_done ? '0 : w_row_sum;
        n_row_has_bright = w_row_done ? 1'b0 : w_row_bright;
        n_img_sum        = w_img_sum;
        n_lead_cnt       = w_lead_cnt;
        n_still_lead     = w_still_lead;
        n_trail_cnt      = w_trail_cnt;
        n_row_cnt        = w_row_cnt;
        // clear for the next image
        if (i_image_end) begin
            n_img_sum    = '0;
            n_lead_cnt   = '0;
            n_still_lead = 1'b1;
            n_trail_cnt  = '0;
            n_row_cnt    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_sum        <= '0;
            r_row_has_bright <= 1'b0;
            r_img_sum        <= '0;
            r_lead_cnt       <= '0;
            r_still_lead     <= 1'b1;
            r_trail_cnt      <= '0;
            r_row_cnt        <= '0;
        end else if (w_accept) begin
            r_row_sum        <= n_row_sum;
            r_row_has_bright <= n_row_has_bright;
            r_img_sum        <= n_img_sum;
            r_lead_cnt       <= n_lead_cnt;
            r_still_lead     <= n_still_lead;
            r_trail_cnt      <= n_trail_cnt;
            r_row_cnt        <= n_row_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && i_image_end) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_image_end) begin
            r_outcome     <= w_outcome;
            r_total_rows  <= w_row_cnt;
            r_top_rows    <= (w_outcome == OUTCOME_CROP) ? w_lead_cnt  : '0;
            r_bottom_rows <= (w_outcome == OUTCOME_CROP) ? w_trail_cnt : '0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_top_rows    = r_top_rows;
    assign o_bottom_rows = r_bottom_rows;
    assign o_outcome     = r_outcome;
    assign o_total_rows  = r_total_rows;

    a_lead_tracks_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_still_lead |-> (r_lead_cnt == r_row_cnt))
        else $error("leading run differs from row count while still leading");

    a_trail_le_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trail_cnt <= r_row_cnt)
        else $error("trailing run exceeds row count");

    a_no_crop_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_outcome != OUTCOME_CROP)) |->
            ((o_top_rows == '0) && (o_bottom_rows == '0)))
        else $error("crop counts set on an uncropped outcome");

    a_crop_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_top_rows <= o_total_rows) && (o_bottom_rows <= o_total_rows))
        else $error("crop count exceeds total rows");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_image_end) |=> o_valid)
        else $error("no result after image end word");

endmodule

[tb/letterbox_bar_detector_unit_checker.sv]
`timescale 1ns / 1ps

module letterbox_bar_detector_unit_checker #(
    parameter int MAX_ROWS = lbd_pkg::MAX_ROWS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lbd_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lbd_pkg::APB_DATA_W-1:0] pwdata,
    input  logic [lbd_pkg::APB_DATA_W-1:0] prdata,
    input  logic                           pready,

    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic [lbd_pkg::SAMPLE_W-1:0]   i_sample,
    input  logic                           i_row_end,
    input  logic                           i_image_end,

    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [lbd_pkg::CNT_W-1:0]      i_top_rows,
    input  logic [lbd_pkg::CNT_W-1:0]      i_bottom_rows,
    input  logic [1:0]                     i_outcome,
    input  logic [lbd_pkg::CNT_W-1:0]      i_total_rows,

    output int                             o_fail_count,
    output int                             o_pending
);

    import lbd_pkg::*;

    localparam int ROW_CAP = (MAX_ROWS < CNT_LIMIT) ? MAX_ROWS : CNT_LIMIT;

    typedef struct packed {
        logic [CNT_W-1:0] top;
        logic [CNT_W-1:0] bottom;
        t_outcome         outcome;
        logic [CNT_W-1:0] total;
    } t_crop;

    // Threshold shadows, tracked from the APB writes
    logic [ROW_SUM_W-1:0] row_sum_lim;
    logic [IMG_LIM_W-1:0] img_sum_lim;
    logic [LEVEL_W-1:0]   bright_lvl;

    logic [ROW_SUM_W-1:0] row_acc;
    logic                 row_bright;
    logic [IMG_SUM_W-1:0] img_acc;
    logic [CNT_W-1:0]     lead_rows;
    logic                 in_lead;
    logic [CNT_W-1:0]     trail_rows;
    logic [CNT_W-1:0]     seen_rows;

    t_crop pending_crops[$];
    int    fails = 0;

    assign o_fail_count = fails;

    function automatic logic [CNT_W-1:0] bump_rows(input logic [CNT_W-1:0] v);
        return (v < ROW_CAP) ? CNT_W'(v + 1) : v;
    endfunction

    task automatic start_image();
        row_acc    = '0;
        row_bright = 1'b0;
        img_acc    = '0;
        lead_rows  = '0;
        in_lead    = 1'b1;
        trail_rows = '0;
        seen_rows  = '0;
    endtask

    task automatic absorb_sample(input logic [SAMPLE_W-1:0] s, input logic re,
                                 input logic ie);
        logic [ROW_SUM_W:0] row_next;
        logic [IMG_SUM_W:0] img_next;
        logic               is_bar;
        t_crop              crop;
        // saturate both sums on carry out
        row_next = {1'b0, row_acc} + (ROW_SUM_W+1)'(s);
        img_next = {1'b0, img_acc} + (IMG_SUM_W+1)'(s);
        row_acc  = row_next[ROW_SUM_W] ? {ROW_SUM_W{1'b1}} : row_next[ROW_SUM_W-1:0];
        img_acc  = img_next[IMG_SUM_W] ? {IMG_SUM_W{1'b1}} : img_next[IMG_SUM_W-1:0];
        if (s > bright_lvl)
            row_bright = 1'b1;
        // image end closes the open row even without a row end
        if (re || ie) begin
            is_bar    = (row_acc < row_sum_lim) && !row_bright;
            seen_rows = bump_rows(seen_rows);
            if (is_bar) begin
                if (in_lead)
                    lead_rows = bump_rows(lead_rows);
                trail_rows = bump_rows(trail_rows);
            end else begin
                in_lead    = 1'b0;
                trail_rows = '0;
            end
            row_acc    = '0;
            row_bright = 1'b0;
        end
        if (ie) begin
            crop.total = seen_rows;
            if (img_acc < img_sum_lim) begin
                crop.outcome = OUTCOME_DARK;
                crop.top     = '0;
                crop.bottom  = '0;
            end else if (in_lead) begin
                crop.outcome = OUTCOME_ALL_BARS;
                crop.top     = '0;
                crop.bottom  = '0;
            end else begin
                crop.outcome = OUTCOME_CROP;
                crop.top     = lead_rows;
                crop.bottom  = trail_rows;
            end
            pending_crops.push_back(crop);
            start_image();
        end
    endtask

    task automatic check_field(input string what, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (got !== want) begin
            fails++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_reg_idx              idx;
        logic [APB_DATA_W-1:0] shadow;
        t_crop                 crop;
        if (!i_rst_n) begin
            row_sum_lim = ROW_SUM_LIMIT_RST;
            img_sum_lim = IMG_SUM_LIMIT_RST;
            bright_lvl  = BRIGHT_LEVEL_RST;
            start_image();
            pending_crops.delete();
        end else begin
            if (psel && penable && pready) begin
                idx = t_reg_idx'(paddr[APB_ADDR_W-1:3]);
                if (pwrite) begin
                    case (idx)
                        REG_ROW_SUM_LIMIT: row_sum_lim = pwdata[ROW_SUM_W-1:0];
                        REG_IMG_SUM_LIMIT: img_sum_lim = pwdata[IMG_LIM_W-1:0];
                        REG_BRIGHT_LEVEL:  bright_lvl  = pwdata[LEVEL_W-1:0];
                        default: ;
                    endcase
                end else begin
                    case (idx)
                        REG_ROW_SUM_LIMIT: shadow = APB_DATA_W'(row_sum_lim);
                        REG_IMG_SUM_LIMIT: shadow = APB_DATA_W'(img_sum_lim);
                        REG_BRIGHT_LEVEL:  shadow = APB_DATA_W'(bright_lvl);
                        default:           shadow = '0;
                    endcase
                    if (prdata !== shadow) begin
                        fails++;
                        $display("%0t: register %0d readback, expected 0x%0h, actual 0x%0h",
                                 $time, idx, shadow, prdata);
                    end
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (pending_crops.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result word, expected none, %s %0d/%0d/%0d/%0d",
                             $time, "actual", i_top_rows, i_bottom_rows, i_outcome,
                             i_total_rows);
                end else begin
                    crop = pending_crops.pop_front();
                    check_field("top_rows", crop.top, i_top_rows);
                    check_field("bottom_rows", crop.bottom, i_bottom_rows);
                    check_field("outcome", CNT_W'(crop.outcome), CNT_W'(i_outcome));
                    check_field("total_rows", crop.total, i_total_rows);
                end
            end
            if (i_in_valid && i_in_ready)
                absorb_sample(i_sample, i_row_end, i_image_end);
        end
        o_pending <= pending_crops.size();
    end

endmodule

[tb/letterbox_bar_detector_unit_test.sv]
`timescale 1ns / 1ps

module letterbox_bar_detector_unit_test;

    import lbd_pkg::*;

    localparam int SETTLE      = 8;
    localparam int QUIET_LIMIT = 2000;
    localparam int RAND_WORDS  = 750;
    localparam int PHASES      = 8;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_valid;
    logic                  o_ready;
    logic [SAMPLE_W-1:0]   i_sample;
    logic                  i_row_end;
    logic                  i_image_end;
    logic                  o_valid;
    logic                  i_ready;
    logic [CNT_W-1:0]      o_top_rows;
    logic [CNT_W-1:0]      o_bottom_rows;
    logic [1:0]            o_outcome;
    logic [CNT_W-1:0]      o_total_rows;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    int words_sent   = 0;
    int gap_pct      = 20;
    bit calm         = 1'b0;

    // current thresholds, used to shape bar rows
    logic [ROW_SUM_W-1:0] cur_row_lim;
    logic [LEVEL_W-1:0]   cur_bright;

    letterbox_bar_detector_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample      (i_sample),
        .i_row_end     (i_row_end),
        .i_image_end   (i_image_end),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_top_rows    (o_top_rows),
        .o_bottom_rows (o_bottom_rows),
        .o_outcome     (o_outcome),
        .o_total_rows  (o_total_rows)
    );

    letterbox_bar_detector_unit_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_sample      (i_sample),
        .i_row_end     (i_row_end),
        .i_image_end   (i_image_end),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_top_rows    (o_top_rows),
        .i_bottom_rows (o_bottom_rows),
        .i_outcome     (o_outcome),
        .i_total_rows  (o_total_rows),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side: random stall bursts, none once calm
    initial begin
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("letterbox_bar_detector_unit test failed");
        $finish;
    end

    task automatic push_word(input logic [SAMPLE_W-1:0] s, input logic re, input logic ie);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample    <= s;
        i_row_end   <= re;
        i_image_end <= ie;
        @(posedge i_clk);
        while (o_ready !== 1'b1) @(posedge i_clk);
        words_sent++;
    endtask

    // hold the sender until every result is back, then let the pipe settle
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [APB_DATA_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        // read it back
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_thresholds(input logic [ROW_SUM_W-1:0] row_lim,
                                  input logic [IMG_LIM_W-1:0] img_lim,
                                  input logic [LEVEL_W-1:0] lvl);
        write_reg(REG_ROW_SUM_LIMIT, APB_DATA_W'(row_lim));
        write_reg(REG_IMG_SUM_LIMIT, APB_DATA_W'(img_lim));
        write_reg(REG_BRIGHT_LEVEL, APB_DATA_W'(lvl));
        cur_row_lim = row_lim;
        cur_bright  = lvl;
    endtask

    // one image: leading and trailing bar rows around content rows, with
    // ragged rows, an open last row, or fully random flags now and then
    task automatic push_image();
        int                  rows;
        int                  width;
        int                  len;
        int                  lead;
        int                  tail;
        int                  dark_max;
        bit                  ragged;
        bit                  open_end;
        bit                  noisy;
        bit                  last;
        logic [SAMPLE_W-1:0] s;
        rows     = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 10);
        width    = $urandom_range(1, 6);
        ragged   = ($urandom_range(0, 3) == 0);
        open_end = ($urandom_range(0, 3) == 0);
        noisy    = ($urandom_range(0, 9) == 0);
        lead     = $urandom_range(0, rows);
        tail     = $urandom_range(0, rows - lead);
        for (int r = 0; r < rows; r++) begin
            len      = ragged ? $urandom_range(1, 8) : width;
            dark_max = int'(cur_row_lim) / len;
            if (dark_max > int'(cur_bright))
                dark_max = int'(cur_bright);
            for (int c = 0; c < len; c++) begin
                last = (r == rows - 1) && (c == len - 1);
                if (noisy)
                    s = SAMPLE_W'($urandom_range(0, 255));
                else if (r < lead || r >= rows - tail)
                    s = ($urandom_range(0, 15) == 0)
                        ? SAMPLE_W'(cur_bright + $urandom_range(0, 1))
                        : SAMPLE_W'($urandom_range(0, dark_max));
                else
                    s = SAMPLE_W'($urandom_range(0, 255));
                if (noisy)
                    push_word(s, ($urandom_range(0, 2) == 0), last);
                else
                    push_word(s, (c == len - 1) && !(last && open_end), last);
            end
        end
    endtask

    initial begin
        int phase_goal;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        i_valid     <= 1'b0;
        i_sample    <= '0;
        i_row_end   <= 1'b0;
        i_image_end <= 1'b0;
        i_rst_n     <= 1'b0;
        cur_row_lim = ROW_SUM_LIMIT_RST;
        cur_bright  = BRIGHT_LEVEL_RST;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset thresholds: a lone black sample is too dark
        push_word(8'd0, 1'b1, 1'b1);
        wait_idle();
        set_thresholds(ROW_SUM_W'(100), IMG_LIM_W'(100), LEVEL_W'(25));
        // every row a bar
        push_word(8'd20, 1'b0, 1'b0);
        push_word(8'd20, 1'b0, 1'b0);
        push_word(8'd20, 1'b1, 1'b0);
        push_word(8'd20, 1'b0, 1'b0);
        push_word(8'd20, 1'b0, 1'b0);
        push_word(8'd20, 1'b1, 1'b1);
        // no bar rows
        push_word(8'd255, 1'b1, 1'b0);
        push_word(8'd30, 1'b1, 1'b1);
        // ragged rows, last row closed by image end alone
        push_word(8'd0, 1'b1, 1'b0);
        push_word(8'd5, 1'b0, 1'b0);
        push_word(8'd5, 1'b1, 1'b0);
        push_word(8'd255, 1'b1, 1'b0);
        push_word(8'd0, 1'b0, 1'b1);
        // bright level edge
        push_word(8'd25, 1'b0, 1'b0);
        push_word(8'd25, 1'b1, 1'b0);
        push_word(8'd26, 1'b1, 1'b0);
        push_word(8'd25, 1'b1, 1'b1);
        // row sum equal to the limit is not a bar
        push_word(8'd50, 1'b0, 1'b0);
        push_word(8'd50, 1'b1, 1'b0);
        push_word(8'd1, 1'b1, 1'b1);
        wait_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0)
                set_thresholds('0, '0, '0);
            else if (ph == 1)
                set_thresholds({ROW_SUM_W{1'b1}}, {IMG_LIM_W{1'b1}}, {LEVEL_W{1'b1}});
            else if ($urandom_range(0, 3) == 0)
                set_thresholds(ROW_SUM_W'($urandom), IMG_LIM_W'({$urandom, $urandom}),
                               LEVEL_W'($urandom));
            else
                set_thresholds(ROW_SUM_W'($urandom_range(0, 1500)),
                               IMG_LIM_W'($urandom_range(0, 4000)),
                               LEVEL_W'($urandom_range(0, 90)));
            calm       = (ph == PHASES - 1);
            gap_pct    = (ph % 3 == 2) ? 0 : $urandom_range(5, 40);
            phase_goal = words_sent + RAND_WORDS / PHASES;
            while (words_sent < phase_goal)
                push_image();
            wait_idle();
        end

        if (fail_count == 0)
            $display("letterbox_bar_detector_unit test passed");
        else
            $display("letterbox_bar_detector_unit test failed");
        $finish;
    end

endmodule

[letterbox_bar_detector_unit.f]
hdl/lbd_pkg.sv
hdl/letterbox_bar_detector_unit.sv
tb/letterbox_bar_detector_unit_checker.sv
tb/letterbox_bar_detector_unit_test.sv
